FILE: rtl/tlqs_pkg.sv
// Package for the two-level queue scheduler.
// Holds queue sizing, the job entry type, result and function codes and the
// command structs used by the controller, datapath and rings.
package tlqs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = IDX_W + 1;

  localparam logic [7:0] QUANTUM_RESET = 8'd4;

  // Result status codes
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_RAN_HIGH = 3'd1;
  localparam logic [2:0] ST_RAN_LOW  = 3'd2;
  localparam logic [2:0] ST_ACCEPT   = 3'd3;
  localparam logic [2:0] ST_REJECT   = 3'd4;

  // Input function codes
  localparam logic FUNC_ARRIVE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] remaining;
    logic        started;
  } job_t;

  // Ring command: push at tail, pop at head, rewrite head in place
  typedef struct packed {
    logic push;
    job_t push_entry;
    logic pop;
    logic upd;
    job_t upd_entry;
  } ring_cmd_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;
    logic arrive;
    logic rotate;
    logic run;
  } dp_cmd_t;

endpackage

FILE: rtl/tlqs_ring.sv
// Circular job queue of QUEUE_DEPTH entries with head pointer and count.
// Depends on tlqs_pkg for the entry type, sizing and ring command struct.
module tlqs_ring
  import tlqs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  ring_cmd_t  cmd,
  output job_t       head_entry,
  output logic [CNT_W-1:0] count,
  output logic       full
);

  job_t              slot_r [QUEUE_DEPTH];
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  tail_sum;
  logic [IDX_W-1:0]  tail_idx;

  // Locate the tail slot, wrapping once past the end
  always_comb begin
    tail_sum = CNT_W'(head_r) + count_r;
    if (tail_sum >= CNT_W'(QUEUE_DEPTH)) begin
      tail_idx = IDX_W'(tail_sum - CNT_W'(QUEUE_DEPTH));
    end else begin
      tail_idx = IDX_W'(tail_sum);
    end
  end

  // Advance head and count
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.pop) begin
      head_nxt = (head_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    unique case ({cmd.push, cmd.pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Store entries; head rewrite and tail push never coincide
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      slot_r[tail_idx] <= cmd.push_entry;
    end else if (cmd.upd) begin
      slot_r[head_r] <= cmd.upd_entry;
    end
  end

  assign head_entry = slot_r[head_r];
  assign count      = count_r;
  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));

endmodule

FILE: rtl/tlqs_datapath.sv
// Scheduler datapath: item latch, quantum register, slice and tick state,
// the two job rings and the registered result. Depends on tlqs_pkg, tlqs_ring.
module tlqs_datapath
  import tlqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  in_job_id,
  input  logic [15:0] in_burst,
  input  logic        in_high_queue,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [7:0]  out_running_id,
  output logic [31:0] out_slot_time,
  output logic        out_first_run,
  output logic        out_finished
);

  logic [7:0]  id_r;
  logic [15:0] burst_r;
  logic        hq_r;
  logic [7:0]  quantum_r;
  logic [7:0]  slice_r, slice_nxt;
  logic        low_run_r, low_run_nxt;
  logic [31:0] tick_r, tick_nxt;

  logic        valid_r;
  logic [2:0]  status_r, status_nxt;
  logic [7:0]  rid_r, rid_nxt;
  logic [31:0] stime_r;
  logic        first_r, first_nxt;
  logic        fin_r, fin_nxt;

  ring_cmd_t        hcmd, lcmd;
  job_t             hhead, lhead;
  logic [CNT_W-1:0] hcnt, lcnt;
  logic             hfull, lfull;

  logic [7:0]  q_eff;
  logic        pick_low, pick_high;
  job_t        cur, upd;
  logic        done;
  job_t        new_job;

  tlqs_ring u_high (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (hcmd),
    .head_entry (hhead),
    .count      (hcnt),
    .full       (hfull)
  );

  tlqs_ring u_low (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (lcmd),
    .head_entry (lhead),
    .count      (lcnt),
    .full       (lfull)
  );

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      id_r    <= in_job_id;
      burst_r <= in_burst;
      hq_r    <= in_high_queue;
    end
  end

  // Write the quantum register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANTUM_RESET;
    end else if (cfg_we) begin
      quantum_r <= cfg_wdata;
    end
  end

  // Pick the job for this time unit and compute its updated entry
  always_comb begin
    q_eff     = (quantum_r == 8'd0) ? 8'd1 : quantum_r;
    pick_low  = (low_run_r && lcnt != '0) || (hcnt == '0 && lcnt != '0);
    pick_high = !(low_run_r && lcnt != '0) && hcnt != '0;
    cur       = pick_high ? hhead : lhead;
    upd.id        = cur.id;
    upd.started   = 1'b1;
    upd.remaining = (cur.remaining != 16'd0) ? cur.remaining - 16'd1 : cur.remaining;
    done          = (upd.remaining == 16'd0);
    new_job.id        = id_r;
    new_job.remaining = burst_r;
    new_job.started   = 1'b0;
  end

  // Drive ring commands, slice, low-running flag, tick and result fields
  always_comb begin
    hcmd        = '0;
    lcmd        = '0;
    slice_nxt   = slice_r;
    low_run_nxt = low_run_r;
    tick_nxt    = tick_r;
    status_nxt  = ST_IDLE;
    rid_nxt     = 8'd0;
    first_nxt   = 1'b0;
    fin_nxt     = 1'b0;
    if (cmd.arrive) begin
      rid_nxt    = id_r;
      status_nxt = ST_REJECT;
      if (burst_r != 16'd0) begin
        if (hq_r && !hfull) begin
          hcmd.push       = 1'b1;
          hcmd.push_entry = new_job;
          status_nxt      = ST_ACCEPT;
        end else if (!hq_r && !lfull) begin
          lcmd.push       = 1'b1;
          lcmd.push_entry = new_job;
          status_nxt      = ST_ACCEPT;
        end
      end
    end
    // Rotate an expired high job to the tail
    if (cmd.rotate && slice_r != 8'd0 && slice_r >= q_eff && hcnt != '0) begin
      hcmd.pop        = 1'b1;
      hcmd.push       = 1'b1;
      hcmd.push_entry = hhead;
      slice_nxt       = 8'd0;
    end
    if (cmd.run) begin
      tick_nxt = tick_r + 32'd1;
      if (pick_high) begin
        hcmd.upd       = 1'b1;
        hcmd.upd_entry = upd;
        hcmd.pop       = done;
        low_run_nxt    = 1'b0;
        if (done) begin
          slice_nxt = 8'd0;
        end else if (slice_r != 8'hFF) begin
          slice_nxt = slice_r + 8'd1;
        end
        status_nxt = ST_RAN_HIGH;
      end else if (pick_low) begin
        lcmd.upd       = 1'b1;
        lcmd.upd_entry = upd;
        lcmd.pop       = done;
        low_run_nxt    = !done;
        status_nxt     = ST_RAN_LOW;
      end else begin
        low_run_nxt = 1'b0;
      end
      if (pick_high || pick_low) begin
        rid_nxt   = cur.id;
        first_nxt = !cur.started;
        fin_nxt   = done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_r   <= 8'd0;
      low_run_r <= 1'b0;
      tick_r    <= 32'd0;
      valid_r   <= 1'b0;
    end else begin
      slice_r   <= slice_nxt;
      low_run_r <= low_run_nxt;
      tick_r    <= tick_nxt;
      valid_r   <= cmd.arrive | cmd.run;
    end
  end

  // Register the result for one cycle of strobe
  always_ff @(posedge clk) begin
    if (cmd.arrive || cmd.run) begin
      status_r <= status_nxt;
      rid_r    <= rid_nxt;
      stime_r  <= tick_r;
      first_r  <= first_nxt;
      fin_r    <= fin_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_status     = status_r;
  assign out_running_id = rid_r;
  assign out_slot_time  = stime_r;
  assign out_first_run  = first_r;
  assign out_finished   = fin_r;

endmodule

FILE: rtl/tlqs_ctrl.sv
// Scheduler controller: sequences arrival and tick items through the datapath.
// Depends on tlqs_pkg for the command struct and function codes.
module tlqs_ctrl
  import tlqs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  logic    in_func,
  output logic    busy,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ARRIVE = 4'b0010,
    S_ROTATE = 4'b0100,
    S_RUN    = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Select next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (in_func == FUNC_TICK) ? S_ROTATE : S_ARRIVE;
        end
      end
      S_ARRIVE: state_nxt = S_IDLE;
      S_ROTATE: state_nxt = S_RUN;
      S_RUN:    state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode datapath commands
  always_comb begin
    cmd.latch  = (state_r == S_IDLE) && start;
    cmd.arrive = (state_r == S_ARRIVE);
    cmd.rotate = (state_r == S_ROTATE);
    cmd.run    = (state_r == S_RUN);
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: rtl/two_level_queue_scheduler_top.sv
// Two-level queue scheduler: round-robin high queue, first-come low queue.
// An arrival passes through the ARRIVE state and a tick through ROTATE then RUN before out_valid
// strobes; a new item is taken only in IDLE, so none is accepted while busy.
// Results strobe for one cycle; the receiver cannot stall.
// Synchronous active-low reset empties both queues, clears slice, tick count
// and low-running flag, and sets quantum to 4. Depends on tlqs_pkg and submodules.
module two_level_queue_scheduler_top
  import tlqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [7:0]  in_job_id,
  input  logic [15:0] in_burst,
  input  logic        in_high_queue,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [7:0]  out_running_id,
  output logic [31:0] out_slot_time,
  output logic        out_first_run,
  output logic        out_finished
);

  dp_cmd_t cmd;

  tlqs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .busy    (busy),
    .cmd     (cmd)
  );

  tlqs_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_job_id      (in_job_id),
    .in_burst       (in_burst),
    .in_high_queue  (in_high_queue),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_running_id (out_running_id),
    .out_slot_time  (out_slot_time),
    .out_first_run  (out_first_run),
    .out_finished   (out_finished)
  );

endmodule
